/* rtl/core/kcl_pkg.sv */
// Shared types, constants and codes for the keypad combination lock.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

    // Digit count: default and legal range
    localparam int DIGITS_DEF = 4;
    localparam int DIGITS_MIN = 1;
    localparam int DIGITS_MAX = 8;

    // Digits that take part in a UART code change
    localparam int UART_DIGITS_MAX = 4;

    // Keypad ladder windows, both ends exclusive
    localparam logic [11:0] SEL_LO   = 12'd610;
    localparam logic [11:0] SEL_HI   = 12'd620;
    localparam logic [11:0] LEFT_LO  = 12'd850;
    localparam logic [11:0] LEFT_HI  = 12'd860;
    localparam logic [11:0] RIGHT_LO = 12'd815;
    localparam logic [11:0] RIGHT_HI = 12'd825;
    localparam logic [11:0] UP_LO    = 12'd925;
    localparam logic [11:0] UP_HI    = 12'd935;
    localparam logic [11:0] DOWN_LO  = 12'd895;
    localparam logic [11:0] DOWN_HI  = 12'd905;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [3:0] DIGIT_TOP  = 4'd9;

    // Servo compare defaults
    localparam logic [15:0] OPEN_DUTY_RST  = 16'd25;
    localparam logic [15:0] CLOSE_DUTY_RST = 16'd75;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_DUTY  = 1'b0,
        REG_CLOSE_DUTY = 1'b1
    } t_cfg_reg;

    // Input commands
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_BUTTON = 2'd1,
        CMD_UART   = 2'd2,
        CMD_IDLE   = 2'd3
    } t_cmd;

    // Result events
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_OPEN   = 3'd1,
        EV_WRONG  = 3'd2,
        EV_STORED = 3'd3,
        EV_UART   = 3'd4
    } t_event;

    // Decoded keypad key
    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_SELECT,
        KEY_LEFT,
        KEY_RIGHT,
        KEY_UP,
        KEY_DOWN
    } t_key;

    // Input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] adc_value;
        logic        held;
        logic [15:0] encoder_count;
        logic [31:0] uart_check_chars;
        logic [31:0] uart_new_chars;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic        lock_open;
        logic        servo_write;
        logic [15:0] servo_duty;
        logic [1:0]  cursor_pos;
        logic [15:0] entered_code;
        logic [2:0]  event_res;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/core/keypad_combination_lock_unit.sv */
// Top level of the keypad combination lock: handshake registers, config port.
// Depends on kcl_pkg and kcl_core.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   in       | i_in_valid  / o_in_ready    | i_in_beat  (kcl_pkg::t_in_item)
//   out      | o_out_valid / i_out_ready   | o_out_beat (kcl_pkg::t_out_item)
//   config   | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// Each beat gives exactly one result beat, through the input register and then the result register.
// One beat per cycle is sustained while the output is not stalled: the input
// register feeds the state update and the result register in the same cycle.
// Synchronous active-low reset clears the lock state and restores the duties.
// A stalled output holds its beat; the input register then holds one more.
`timescale 1ns / 1ps
`default_nettype none

module keypad_combination_lock_unit #(
    parameter int NUM_DIGITS = kcl_pkg::DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire kcl_pkg::t_in_item             i_in_beat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output kcl_pkg::t_out_item                 o_out_beat,
    input  wire logic                          i_cfg_we,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data
);

    logic               r_in_valid;
    kcl_pkg::t_in_item  r_in_beat;
    logic               r_out_valid;
    kcl_pkg::t_out_item r_out_beat;
    logic [15:0]        r_open_duty;
    logic [15:0]        r_close_duty;
    logic               w_step;
    kcl_pkg::t_out_item w_result;

    // Advance when the held beat can move into the result register
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    kcl_core #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in_beat),
        .i_open_duty  (r_open_duty),
        .i_close_duty (r_close_duty),
        .o_result     (w_result)
    );

    // Handshake valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_beat;
        end
        if (w_step) begin
            r_out_beat <= w_result;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_duty  <= kcl_pkg::OPEN_DUTY_RST;
            r_close_duty <= kcl_pkg::CLOSE_DUTY_RST;
        end else if (i_cfg_we) begin
            case (kcl_pkg::t_cfg_reg'(i_cfg_idx))
                kcl_pkg::REG_OPEN_DUTY:  r_open_duty  <= i_cfg_data;
                kcl_pkg::REG_CLOSE_DUTY: r_close_duty <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kcl_key_decode.sv */
// Keypad resistor ladder decoder: ADC sample to key code.
// Depends on kcl_pkg for window bounds and the key type.
`timescale 1ns / 1ps
`default_nettype none

module kcl_key_decode (
    input  wire logic [11:0] i_adc_value,
    output kcl_pkg::t_key    o_key
);

    // Windows are disjoint; order follows the keypad priority anyway
    always_comb begin
        if (i_adc_value > kcl_pkg::SEL_LO && i_adc_value < kcl_pkg::SEL_HI) begin
            o_key = kcl_pkg::KEY_SELECT;
        end else if (i_adc_value > kcl_pkg::LEFT_LO && i_adc_value < kcl_pkg::LEFT_HI) begin
            o_key = kcl_pkg::KEY_LEFT;
        end else if (i_adc_value > kcl_pkg::RIGHT_LO && i_adc_value < kcl_pkg::RIGHT_HI) begin
            o_key = kcl_pkg::KEY_RIGHT;
        end else if (i_adc_value > kcl_pkg::UP_LO && i_adc_value < kcl_pkg::UP_HI) begin
            o_key = kcl_pkg::KEY_UP;
        end else if (i_adc_value > kcl_pkg::DOWN_LO && i_adc_value < kcl_pkg::DOWN_HI) begin
            o_key = kcl_pkg::KEY_DOWN;
        end else begin
            o_key = kcl_pkg::KEY_NONE;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kcl_core.sv */
// Lock state (codes, cursor, lock, encoder reference) and its update logic.
// Depends on kcl_pkg and kcl_key_decode.
`timescale 1ns / 1ps
`default_nettype none

module kcl_core #(
    parameter int NUM_DIGITS = kcl_pkg::DIGITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire kcl_pkg::t_in_item   i_item,
    input  wire logic [15:0]         i_open_duty,
    input  wire logic [15:0]         i_close_duty,
    output kcl_pkg::t_out_item       o_result
);

    localparam int CurW     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CurExtW  = (CurW > 2) ? CurW : 2;
    localparam int UartDig  = (NUM_DIGITS < kcl_pkg::UART_DIGITS_MAX) ?
                              NUM_DIGITS : kcl_pkg::UART_DIGITS_MAX;
    localparam int ShowDig  = UartDig;
    localparam logic [CurW-1:0] LastPos = CurW'(NUM_DIGITS - 1);

    // State
    logic [NUM_DIGITS-1:0][3:0] r_stored,  n_stored;
    logic [NUM_DIGITS-1:0][3:0] r_entered, n_entered;
    logic [CurW-1:0]            r_cursor,  n_cursor;
    logic                       r_is_open, n_is_open;
    logic [15:0]                r_enc_ref, n_enc_ref;

    kcl_pkg::t_key   w_key;
    kcl_pkg::t_event w_event;
    logic            w_select;
    logic            w_step_up;
    logic            w_step_dn;
    logic            w_code_ok;
    logic            w_uart_ok;
    logic            w_srv_wr;
    logic [15:0]     w_srv_duty;
    logic [3:0]      w_cur_digit;
    logic [15:0]     w_code;
    logic [CurExtW-1:0] w_cur_ext;

    kcl_key_decode u_key_decode (
        .i_adc_value (i_item.adc_value),
        .o_key       (w_key)
    );

    // Compares: entered vs stored, and UART check chars vs entered
    always_comb begin
        w_code_ok = (r_stored == r_entered);
        w_uart_ok = 1'b1;
        for (int i = 0; i < UartDig; i++) begin
            if (i_item.uart_check_chars[8*i +: 8] !=
                ({4'd0, r_entered[i]} + kcl_pkg::ASCII_ZERO)) begin
                w_uart_ok = 1'b0;
            end
        end
    end

    assign w_cur_digit = r_entered[r_cursor];

    // Command decode and next state
    always_comb begin
        n_stored   = r_stored;
        n_entered  = r_entered;
        n_cursor   = r_cursor;
        n_is_open  = r_is_open;
        n_enc_ref  = r_enc_ref;
        w_event    = kcl_pkg::EV_NONE;
        w_select   = 1'b0;
        w_step_up  = 1'b0;
        w_step_dn  = 1'b0;
        w_srv_wr   = 1'b0;
        w_srv_duty = '0;

        case (kcl_pkg::t_cmd'(i_item.cmd))
            kcl_pkg::CMD_SAMPLE: begin
                case (w_key)
                    kcl_pkg::KEY_SELECT: begin
                        w_select = 1'b1;
                    end
                    kcl_pkg::KEY_LEFT: begin
                        if (!i_item.held && r_cursor != '0) begin
                            n_cursor = r_cursor - 1'b1;
                        end
                    end
                    kcl_pkg::KEY_RIGHT: begin
                        if (!i_item.held && r_cursor < LastPos) begin
                            n_cursor = r_cursor + 1'b1;
                        end
                    end
                    kcl_pkg::KEY_UP: begin
                        w_step_up = !i_item.held;
                    end
                    kcl_pkg::KEY_DOWN: begin
                        w_step_dn = !i_item.held;
                    end
                    default: begin
                        // no key: rotary encoder steps the digit, held ignored
                        if (i_item.encoder_count != r_enc_ref) begin
                            w_step_dn = (i_item.encoder_count < r_enc_ref);
                            w_step_up = !(i_item.encoder_count < r_enc_ref);
                            n_enc_ref = i_item.encoder_count;
                        end
                    end
                endcase
            end
            kcl_pkg::CMD_BUTTON: begin
                // push advances the cursor, selects at the last position
                if (!i_item.held) begin
                    if (r_cursor < LastPos) begin
                        n_cursor = r_cursor + 1'b1;
                    end else begin
                        w_select = 1'b1;
                    end
                end
            end
            kcl_pkg::CMD_UART: begin
                if (w_uart_ok) begin
                    for (int i = 0; i < UartDig; i++) begin
                        // low nibble of (char - '0'); '0' has a zero low nibble
                        n_stored[i] = i_item.uart_new_chars[8*i +: 4];
                    end
                    w_event = kcl_pkg::EV_UART;
                end
            end
            default: begin
            end
        endcase

        // Saturating digit step at the cursor
        if (w_step_up && w_cur_digit < kcl_pkg::DIGIT_TOP) begin
            n_entered[r_cursor] = w_cur_digit + 4'd1;
        end else if (w_step_dn && w_cur_digit != 4'd0) begin
            n_entered[r_cursor] = w_cur_digit - 4'd1;
        end

        // Select: check code when closed, store code when open
        if (w_select) begin
            w_srv_wr = 1'b1;
            if (!r_is_open) begin
                if (w_code_ok) begin
                    w_srv_duty = i_open_duty;
                    n_is_open  = 1'b1;
                    w_event    = kcl_pkg::EV_OPEN;
                end else begin
                    w_srv_duty = i_close_duty;
                    w_event    = kcl_pkg::EV_WRONG;
                end
            end else begin
                n_stored   = r_entered;
                n_entered  = '0;
                w_srv_duty = i_close_duty;
                n_is_open  = 1'b0;
                w_event    = kcl_pkg::EV_STORED;
            end
        end
    end

    // Result beat
    always_comb begin
        w_code = '0;
        for (int i = 0; i < ShowDig; i++) begin
            w_code[4*i +: 4] = n_entered[i];
        end
    end

    assign w_cur_ext = CurExtW'(n_cursor);

    always_comb begin
        o_result.lock_open    = n_is_open;
        o_result.servo_write  = w_srv_wr;
        o_result.servo_duty   = w_srv_duty;
        o_result.cursor_pos   = w_cur_ext[1:0];
        o_result.entered_code = w_code;
        o_result.event_res    = w_event;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored  <= '0;
            r_entered <= '0;
            r_cursor  <= '0;
            r_is_open <= 1'b0;
            r_enc_ref <= '0;
        end else if (i_step) begin
            r_stored  <= n_stored;
            r_entered <= n_entered;
            r_cursor  <= n_cursor;
            r_is_open <= n_is_open;
            r_enc_ref <= n_enc_ref;
        end
    end

    // Checks
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= LastPos)
        else $error("cursor beyond last digit");

    a_open_sets_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.event_res == kcl_pkg::EV_OPEN |=> r_is_open)
        else $error("open event without lock open");

    a_store_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.event_res == kcl_pkg::EV_STORED
        |=> r_entered == '0 && !r_is_open)
        else $error("code store did not clear digits and close");

    a_servo_on_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> o_result.servo_write ==
            (o_result.event_res == kcl_pkg::EV_OPEN ||
             o_result.event_res == kcl_pkg::EV_WRONG ||
             o_result.event_res == kcl_pkg::EV_STORED))
        else $error("servo write not tied to a select event");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_stored) && $stable(r_entered) && $stable(r_cursor)
                    && $stable(r_is_open))
        else $error("lock state changed without a beat");

endmodule

`default_nettype wire
